// File: hdl/rsfp_pkg.sv
// Shared types and constants for the residency set first-fit placer.
`timescale 1ns / 1ps

package rsfp_pkg;

  localparam int MAX_BINS_DEF    = 16;
  localparam int TRACK_SLOTS_DEF = 256;

  localparam int BYTES_W  = 48;
  localparam int BIN_W    = 5;
  localparam int HANDLE_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIN_W-1:0] NO_BIN = 5'd16;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_ERASE  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_PLACED      = 3'd0,
    ST_UNPLACED    = 3'd1,
    ST_REMOVED     = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_NOT_TRACKED = 3'd4,
    ST_DISABLED    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_BIN_CAP     = 2'd1,
    CFG_WIRED_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_SCAN,
    S_ADD,
    S_RESP
  } state_t;

  typedef struct packed {
    func_t               func;
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  alloc_bytes;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [BIN_W-1:0]   bin_id;
    logic [BYTES_W-1:0] wired_total;
    logic [BIN_W-1:0]   bins_open;
  } out_item_t;

  // one tracking table entry
  typedef struct packed {
    logic               valid;
    logic [BIN_W-1:0]   bin;
    logic [BYTES_W-1:0] bytes;
  } slot_ent_t;

endpackage

// File: hdl/rsfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/residency_set_first_fit_placer_top.sv
// Top level: handle-slot tracking and first-fit bin placement over two RAMs.
// Flow: a disabled or out-of-range item goes straight to the result step; others
//   read their slot first, errors and unplaced items then respond, a placed erase
//   or a zero-cap insert updates its bin, and other inserts scan the open bins.
// Throughput: one item at a time; the bin scan reads one bin size per cycle from
//   the bin RAM.
// Reset: synchronous; a clearing pass zeroes every entry of both RAMs, with
//   in_ready low until it ends (config is always taken).
`timescale 1ns / 1ps

module residency_set_first_fit_placer_top import rsfp_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data
);

  localparam int SW      = $clog2(TRACK_SLOTS);
  localparam int BW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CLR_LEN = (TRACK_SLOTS > MAX_BINS) ? TRACK_SLOTS : MAX_BINS;
  localparam int CLR_W   = $clog2(CLR_LEN);
  localparam int SLOT_W  = $bits(slot_ent_t);

  // config registers
  logic               enable;
  logic [BYTES_W-1:0] bin_cap;
  logic [BYTES_W-1:0] wired_limit;

  state_t             state, state_next;
  logic [CLR_W-1:0]   clr_cnt, clr_cnt_next;
  in_item_t           item, item_next;
  logic [BIN_W-1:0]   open_bins, open_bins_next;
  logic [BYTES_W-1:0] placed_total, placed_total_next;
  logic [BYTES_W-1:0] slot_bytes_q, slot_bytes_q_next;
  logic [BIN_W-1:0]   scan_idx, scan_idx_next;
  logic [BIN_W-1:0]   empty_idx, empty_idx_next;
  logic [BIN_W-1:0]   emp_idx, emp_idx_next;
  logic [BYTES_W-1:0] emp_val, emp_val_next;
  logic [BIN_W-1:0]   chosen, chosen_next;
  status_t            res_status, res_status_next;
  logic [BIN_W-1:0]   res_bin, res_bin_next;
  logic               out_valid_next;
  out_item_t          out_item_next;

  // RAM ports
  logic               slot_we;
  logic [SW-1:0]      slot_waddr, slot_raddr;
  slot_ent_t          slot_wdata, slot_rdata;
  logic [SLOT_W-1:0]  slot_rdata_raw;
  logic               bin_we;
  logic [BW-1:0]      bin_waddr, bin_raddr;
  logic [BYTES_W-1:0] bin_wdata, bin_rdata;

  // datapath
  logic [BYTES_W:0]   lim_sum, fit_sum;
  logic [BIN_W-1:0]   next_idx;
  logic [BIN_W-1:0]   empty_cur, emp_cur_idx;
  logic [BYTES_W-1:0] emp_cur_val;
  logic               commit;
  logic [BIN_W-1:0]   commit_bin;
  logic [BYTES_W-1:0] commit_val;

  rsfp_ram #(.WIDTH(SLOT_W), .DEPTH(TRACK_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata_raw)
  );
  assign slot_rdata = slot_ent_t'(slot_rdata_raw);

  rsfp_ram #(.WIDTH(BYTES_W), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  assign cfg_ready = 1'b1;

  assign lim_sum  = {1'b0, placed_total} + {1'b0, item.alloc_bytes};
  assign fit_sum  = {1'b0, bin_rdata} + {1'b0, item.alloc_bytes};
  assign next_idx = scan_idx + 5'd1;

  // scan bookkeeping including the bin currently on the read port
  always_comb begin
    empty_cur   = empty_idx;
    emp_cur_idx = emp_idx;
    emp_cur_val = emp_val;
    if (scan_idx != '0 && bin_rdata == '0 && empty_idx == NO_BIN) begin
      empty_cur = scan_idx;
    end
    if (scan_idx == '0 || bin_rdata < emp_val) begin
      emp_cur_idx = scan_idx;
      emp_cur_val = bin_rdata;
    end
  end

  always_comb begin
    state_next        = state;
    clr_cnt_next      = clr_cnt;
    item_next         = item;
    open_bins_next    = open_bins;
    placed_total_next = placed_total;
    slot_bytes_q_next = slot_bytes_q;
    scan_idx_next     = scan_idx;
    empty_idx_next    = empty_idx;
    emp_idx_next      = emp_idx;
    emp_val_next      = emp_val;
    chosen_next       = chosen;
    res_status_next   = res_status;
    res_bin_next      = res_bin;
    out_valid_next    = out_valid & ~out_ready;
    out_item_next     = out_item;
    in_ready          = 1'b0;
    slot_we           = 1'b0;
    slot_waddr        = SW'(item.handle);
    slot_wdata        = '0;
    slot_raddr        = SW'(in_item.handle);
    bin_we            = 1'b0;
    bin_waddr         = chosen[BW-1:0];
    bin_wdata         = '0;
    bin_raddr         = '0;
    commit            = 1'b0;
    commit_bin        = chosen;
    commit_val        = '0;

    unique case (state)
      S_CLEAR: begin
        slot_we    = (32'(clr_cnt) < TRACK_SLOTS);
        slot_waddr = clr_cnt[SW-1:0];
        bin_we     = (32'(clr_cnt) < MAX_BINS);
        bin_waddr  = clr_cnt[BW-1:0];
        if (32'(clr_cnt) == CLR_LEN - 1) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + CLR_W'(1);
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next    = in_item;
          res_bin_next = NO_BIN;
          if (!enable) begin
            res_status_next = ST_DISABLED;
            state_next      = S_RESP;
          end else if (32'(in_item.handle) >= TRACK_SLOTS) begin
            res_status_next = ST_NOT_TRACKED;
            state_next      = S_RESP;
          end else begin
            state_next = S_SLOT;
          end
        end
      end

      S_SLOT: begin
        slot_bytes_q_next = slot_rdata.bytes;
        if (item.func == FN_INSERT) begin
          if (slot_rdata.valid) begin
            res_status_next = ST_DUPLICATE;
            state_next      = S_RESP;
          end else if (lim_sum > {1'b0, wired_limit}) begin
            slot_we         = 1'b1;
            slot_wdata      = '{valid: 1'b1, bin: NO_BIN, bytes: item.alloc_bytes};
            res_status_next = ST_UNPLACED;
            state_next      = S_RESP;
          end else if (bin_cap == '0) begin
            chosen_next = '0;
            state_next  = S_ADD;
          end else begin
            scan_idx_next  = '0;
            empty_idx_next = NO_BIN;
            emp_idx_next   = '0;
            state_next     = S_SCAN;
          end
        end else begin
          if (!slot_rdata.valid) begin
            res_status_next = ST_NOT_TRACKED;
            state_next      = S_RESP;
          end else if (slot_rdata.bin < 5'(MAX_BINS)) begin
            bin_raddr   = slot_rdata.bin[BW-1:0];
            chosen_next = slot_rdata.bin;
            state_next  = S_ADD;
          end else begin
            // unplaced allocation: just free the slot
            slot_we         = 1'b1;
            res_status_next = ST_REMOVED;
            state_next      = S_RESP;
          end
        end
      end

      S_SCAN: begin
        empty_idx_next = empty_cur;
        emp_idx_next   = emp_cur_idx;
        emp_val_next   = emp_cur_val;
        if (fit_sum <= {1'b0, bin_cap}) begin
          commit     = 1'b1;
          commit_bin = scan_idx;
          commit_val = fit_sum[BYTES_W-1:0];
        end else if (next_idx < open_bins) begin
          bin_raddr     = next_idx[BW-1:0];
          scan_idx_next = next_idx;
        end else if (empty_cur != NO_BIN) begin
          commit     = 1'b1;
          commit_bin = empty_cur;
          commit_val = item.alloc_bytes;
        end else if (open_bins < 5'(MAX_BINS)) begin
          // open a fresh bin; its prior content is replaced outright
          commit         = 1'b1;
          commit_bin     = open_bins;
          commit_val     = item.alloc_bytes;
          open_bins_next = open_bins + 5'd1;
        end else begin
          commit     = 1'b1;
          commit_bin = emp_cur_idx;
          commit_val = emp_cur_val + item.alloc_bytes;
        end
      end

      S_ADD: begin
        if (item.func == FN_ERASE) begin
          bin_we            = 1'b1;
          bin_wdata         = bin_rdata - slot_bytes_q;
          placed_total_next = placed_total - slot_bytes_q;
          slot_we           = 1'b1;
          res_status_next   = ST_REMOVED;
          res_bin_next      = chosen;
          state_next        = S_RESP;
        end else begin
          commit     = 1'b1;
          commit_bin = chosen;
          commit_val = bin_rdata + item.alloc_bytes;
        end
      end

      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_item_next  = '{status: res_status, bin_id: res_bin,
                             wired_total: placed_total, bins_open: open_bins};
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (commit) begin
      bin_we            = 1'b1;
      bin_waddr         = commit_bin[BW-1:0];
      bin_wdata         = commit_val;
      slot_we           = 1'b1;
      slot_wdata        = '{valid: 1'b1, bin: commit_bin, bytes: item.alloc_bytes};
      placed_total_next = placed_total + item.alloc_bytes;
      res_status_next   = ST_PLACED;
      res_bin_next      = commit_bin;
      state_next        = S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      open_bins    <= 5'd1;
      placed_total <= '0;
      out_valid    <= 1'b0;
      enable       <= 1'b0;
      bin_cap      <= '0;
      wired_limit  <= '0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      open_bins    <= open_bins_next;
      placed_total <= placed_total_next;
      out_valid    <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENABLE:      enable      <= cfg_data[0];
          CFG_BIN_CAP:     bin_cap     <= cfg_data;
          CFG_WIRED_LIMIT: wired_limit <= cfg_data;
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item         <= item_next;
    slot_bytes_q <= slot_bytes_q_next;
    scan_idx     <= scan_idx_next;
    empty_idx    <= empty_idx_next;
    emp_idx      <= emp_idx_next;
    emp_val      <= emp_val_next;
    chosen       <= chosen_next;
    res_status   <= res_status_next;
    res_bin      <= res_bin_next;
    out_item     <= out_item_next;
  end

  // Items run strictly one after another, so a slot write always lands
  // before the next item's slot read; no forwarding path is needed.

  a_open_bins_range: assert property (@(posedge clk) disable iff (rst)
    open_bins >= 5'd1 && open_bins <= 5'(MAX_BINS))
    else $error("open bin count out of range");

  a_placed_bin_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_PLACED |-> out_item.bin_id < out_item.bins_open)
    else $error("placed item reports a bin that is not open");

  a_error_no_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_DUPLICATE || out_item.status == ST_NOT_TRACKED ||
                  out_item.status == ST_DISABLED || out_item.status == ST_UNPLACED)
    |-> out_item.bin_id == NO_BIN)
    else $error("error or unplaced result carries a bin");

  a_resp_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP |-> !slot_we && !bin_we)
    else $error("RAM write while a result is pending");

  a_total_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP) |=> $stable(placed_total))
    else $error("placed total changed outside an update step");

endmodule

// File: dv/residency_set_first_fit_placer_top_test.sv
// Self-checking testbench for the residency set first-fit placer top level.
`timescale 1ns / 1ps

module residency_set_first_fit_placer_top_test;
  import rsfp_pkg::*;

  localparam int MAX_BINS     = MAX_BINS_DEF;
  localparam int TRACK_SLOTS  = TRACK_SLOTS_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTES_W-1:0]   cfg_data;

  // shadow of the block: registers, bin fill and tracking table
  bit                     pl_enable;
  bit   [BYTES_W-1:0]     pl_cap;
  bit   [BYTES_W-1:0]     pl_limit;
  bit   [BYTES_W-1:0]     bin_fill[MAX_BINS];
  int                     bins_live = 1;
  bit   [BYTES_W-1:0]     wired_sum;
  bit                     slot_live[TRACK_SLOTS];
  bit   [BIN_W-1:0]       slot_home[TRACK_SLOTS];
  bit   [BYTES_W-1:0]     slot_size[TRACK_SLOTS];

  out_item_t placements_due[$];
  int        mismatch_count = 0;
  int        tx_idle_pct = 33;
  int        rx_idle_pct = 33;
  int        rx_hold_cycles = 0;

  residency_set_first_fit_placer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // zero cap: bin 0; else first fit, then emptied bin above 0, then a new bin, then the emptiest one
  function automatic logic [BIN_W-1:0] pick_bin(logic [BYTES_W-1:0] sz);
    int n;
    int emptied;
    int lowest;
    if (pl_cap == 0) return '0;
    n = bins_live;
    if (n < 1) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    emptied = MAX_BINS;
    lowest = 0;
    for (int i = 0; i < n; i++) begin
      if ({1'b0, bin_fill[i]} + {1'b0, sz} <= {1'b0, pl_cap}) return BIN_W'(i);
      if (i != 0 && bin_fill[i] == 0 && emptied == MAX_BINS) emptied = i;
      if (bin_fill[i] < bin_fill[lowest]) lowest = i;
    end
    if (emptied != MAX_BINS) return BIN_W'(emptied);
    if (n < MAX_BINS) begin
      bin_fill[n] = '0;
      bins_live = n + 1;
      return BIN_W'(n);
    end
    return BIN_W'(lowest);
  endfunction

  function automatic out_item_t predict_placement(in_item_t it);
    out_item_t        r;
    logic [BIN_W-1:0] b;
    int               h;
    int               bi;
    h = int'(it.handle);
    r.status = ST_DISABLED;
    r.bin_id = NO_BIN;
    if (!pl_enable) begin
      r.status = ST_DISABLED;
    end else if (it.func == FN_INSERT) begin
      if (slot_live[h]) begin
        r.status = ST_DUPLICATE;
      end else begin
        slot_live[h] = 1'b1;
        slot_size[h] = it.alloc_bytes;
        slot_home[h] = NO_BIN;
        if ({1'b0, wired_sum} + {1'b0, it.alloc_bytes} > {1'b0, pl_limit}) begin
          r.status = ST_UNPLACED;
        end else begin
          b = pick_bin(it.alloc_bytes);
          bi = int'(b);
          bin_fill[bi] = bin_fill[bi] + it.alloc_bytes;
          wired_sum = wired_sum + it.alloc_bytes;
          slot_home[h] = b;
          r.status = ST_PLACED;
          r.bin_id = b;
        end
      end
    end else begin
      if (!slot_live[h]) begin
        r.status = ST_NOT_TRACKED;
      end else begin
        if (slot_home[h] < MAX_BINS) begin
          bi = int'(slot_home[h]);
          bin_fill[bi] = bin_fill[bi] - slot_size[h];
          wired_sum = wired_sum - slot_size[h];
          r.bin_id = slot_home[h];
        end
        slot_live[h] = 1'b0;
        slot_home[h] = NO_BIN;
        r.status = ST_REMOVED;
      end
    end
    r.wired_total = wired_sum;
    r.bins_open = bins_live[BIN_W-1:0];
    return r;
  endfunction

  function automatic in_item_t make_op(func_t f, int h, logic [BYTES_W-1:0] sz);
    in_item_t it;
    it.func = f;
    it.handle = HANDLE_W'(h);
    it.alloc_bytes = sz;
    return it;
  endfunction

  // sizes spread around the cap: zero, full width, oversize, and fractions of the cap
  function automatic logic [BYTES_W-1:0] rand_alloc_size();
    logic [63:0]        r;
    logic [BYTES_W-1:0] span;
    r = {$urandom, $urandom};
    span = (pl_cap == 0) ? 48'd4096 : pl_cap >> $urandom_range(3);
    case ($urandom_range(15))
      0: return '0;
      1: return r[BYTES_W-1:0];
      2: return pl_cap + BYTES_W'(r[5:0]) + 48'd1;
      default: return (span == 0) ? 48'd1 : BYTES_W'(r % span) + 48'd1;
    endcase
  endfunction

  // mostly legal churn: insert to a free handle, erase a tracked one; some noise
  function automatic in_item_t next_alloc_op(int hmax, int erase_pct);
    in_item_t it;
    int       start;
    int       h;
    bit       want_erase;
    bit       found;
    it.alloc_bytes = rand_alloc_size();
    if ($urandom_range(99) < 15) begin
      it.func = func_t'($urandom_range(1));
      it.handle = HANDLE_W'($urandom_range(255));
      return it;
    end
    want_erase = $urandom_range(99) < erase_pct;
    start = $urandom_range(hmax);
    found = 1'b0;
    it.handle = HANDLE_W'(start);
    for (int k = 0; k <= hmax && !found; k++) begin
      h = (start + k) % (hmax + 1);
      if (slot_live[h] == want_erase) begin
        found = 1'b1;
        it.handle = HANDLE_W'(h);
      end
    end
    it.func = slot_live[it.handle] ? FN_ERASE : FN_INSERT;
    return it;
  endfunction

  // leaves in_valid high after acceptance so items can go back to back
  task automatic send_item(in_item_t it);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    placements_due = {placements_due, predict_placement(it)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (placements_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [BYTES_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:      pl_enable = data[0];
      CFG_BIN_CAP:     pl_cap = data;
      CFG_WIRED_LIMIT: pl_limit = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(bit en, logic [BYTES_W-1:0] cap, logic [BYTES_W-1:0] lim);
    drain_results();
    write_reg(CFG_ENABLE, {47'd0, en});
    write_reg(CFG_BIN_CAP, cap);
    write_reg(CFG_WIRED_LIMIT, lim);
  endtask

  task automatic run_alloc_traffic(int count, int hmax, int erase_pct);
    repeat (count) send_item(next_alloc_op(hmax, erase_pct));
  endtask

  task automatic test_disabled_block();
    set_config(1'b0, 48'd1000, BYTES_MAX);
    send_item(make_op(FN_INSERT, 0, 48'd5));
    send_item(make_op(FN_ERASE, 0, 48'd0));
    send_item(make_op(FN_INSERT, 255, BYTES_MAX));
    send_item(make_op(FN_ERASE, 200, 48'd0));
    run_alloc_traffic(10, 255, 50);
  endtask

  task automatic test_directed_cases();
    set_config(1'b1, 48'd1000, BYTES_MAX);
    send_item(make_op(FN_INSERT, 0, 48'd0));
    send_item(make_op(FN_INSERT, 255, 48'd1000));     // exact fit in bin 0
    send_item(make_op(FN_INSERT, 1, 48'd1));          // opens bin 1
    send_item(make_op(FN_INSERT, 1, 48'd7));          // duplicate
    send_item(make_op(FN_ERASE, 7, 48'd0));           // never tracked
    send_item(make_op(FN_ERASE, 1, 48'd0));           // bin 1 now empty
    send_item(make_op(FN_INSERT, 2, 48'd2000));       // oversize lands in emptied bin 1
    send_item(make_op(FN_INSERT, 3, BYTES_MAX));      // over the wired limit
    send_item(make_op(FN_ERASE, 3, 48'd0));           // erase of an unplaced item
    send_item(make_op(FN_INSERT, 4, 48'hAAAA_AAAA_AAAA));
    send_item(make_op(FN_ERASE, 4, 48'd0));
    send_item(make_op(FN_INSERT, 5, 48'h5555_5555_5555));
    send_item(make_op(FN_ERASE, 5, 48'd0));
    set_config(1'b1, 48'd0, BYTES_MAX);                // zero cap: everything in bin 0
    send_item(make_op(FN_INSERT, 6, 48'd500));
    send_item(make_op(FN_ERASE, 6, 48'd0));
    set_config(1'b1, 48'd0, 48'd0);
    send_item(make_op(FN_INSERT, 8, 48'd0));
    send_item(make_op(FN_ERASE, 8, 48'd0));
    send_item(make_op(FN_ERASE, 0, 48'd0));
    send_item(make_op(FN_ERASE, 255, 48'd0));
    send_item(make_op(FN_ERASE, 2, 48'd0));
    send_item(make_op(FN_INSERT, 9, 48'd0));          // zero bytes fit a zero limit
    send_item(make_op(FN_INSERT, 10, 48'd1));
    send_item(make_op(FN_ERASE, 9, 48'd0));
    send_item(make_op(FN_ERASE, 10, 48'd0));
  endtask

  task automatic test_first_fit_churn();
    set_config(1'b1, 48'd1000, BYTES_MAX);
    run_alloc_traffic(300, 31, 40);
  endtask

  task automatic test_back_to_back();
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_alloc_traffic(200, 31, 40);
    drain_results();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
  endtask

  // small cap fills all bins, then placement falls back to the emptiest
  task automatic test_full_bin_spread();
    set_config(1'b1, 48'd64, BYTES_MAX);
    run_alloc_traffic(300, 63, 25);
  endtask

  task automatic test_wired_limit();
    set_config(1'b1, 48'd64, 48'd1500);
    run_alloc_traffic(250, 63, 45);
  endtask

  task automatic test_single_bin();
    set_config(1'b1, 48'd0, 48'h100_0000_0000);
    run_alloc_traffic(200, 255, 45);
  endtask

  task automatic test_max_cap();
    set_config(1'b1, BYTES_MAX, BYTES_MAX);
    run_alloc_traffic(200, 255, 50);
  endtask

  task automatic test_zero_limit();
    set_config(1'b1, 48'd300, 48'd0);
    run_alloc_traffic(60, 63, 50);
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_output_backpressure();
    set_config(1'b1, 48'd1000, BYTES_MAX);
    rx_hold_cycles = HOLD_CYCLES;
    run_alloc_traffic(60, 31, 40);
  endtask

  initial begin : result_check
    out_item_t got;
    out_item_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = out_item;
        if (placements_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result st=%0d bin=%0d tot=%0d open=%0d", $realtime,
                     got.status, got.bin_id, got.wired_total, got.bins_open);
        end else begin
          want = placements_due.pop_front();
          if (got.status !== want.status || got.bin_id !== want.bin_id ||
              got.wired_total !== want.wired_total || got.bins_open !== want.bins_open) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, want.status, want.bin_id, want.wired_total,
                       want.bins_open, got.status, got.bin_id, got.wired_total,
                       got.bins_open);
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("FAIL residency_set_first_fit_placer_top");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_disabled_block();
    test_directed_cases();
    test_first_fit_churn();
    test_back_to_back();
    test_full_bin_spread();
    test_wired_limit();
    test_single_bin();
    test_max_cap();
    test_zero_limit();
    test_output_backpressure();
    test_disabled_block();
    drain_results();
    repeat (MAX_BINS + 8) @(posedge clk);
    if (mismatch_count == 0 && placements_due.size() == 0)
      $display("PASS residency_set_first_fit_placer_top");
    else
      $display("FAIL residency_set_first_fit_placer_top");
    $finish;
  end

endmodule

// File: filelist.f
hdl/rsfp_pkg.sv
hdl/rsfp_ram.sv
hdl/residency_set_first_fit_placer_top.sv
dv/residency_set_first_fit_placer_top_test.sv
